FILE: rtl/rci_pkg.sv
// Types and constants shared by the ray/circle intersection unit.
`default_nettype none
package rci_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NORM_BITS  = 16;

  // iteration counts of the digit-recurrence units
  localparam int SQ1_STEPS  = 24;
  localparam int DIV1_STEPS = 32;
  localparam int SQ2_STEPS  = 32;
  localparam int DIV2_STEPS = 16;

  // register stages: 4 front, sqrt + load, divide + load, select, 4 point, sqrt + load,
  // normalize + load, output
  localparam int PIPE_DEPTH = 4 + (SQ1_STEPS + 1) + (DIV1_STEPS + 1) + 1 + 4
                            + (SQ2_STEPS + 1) + (DIV2_STEPS + 1) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [NORM_BITS-1:0]  norm_t;

  typedef struct packed {
    coord_t                  origin_x;
    coord_t                  origin_y;
    coord_t                  dir_x;
    coord_t                  dir_y;
    coord_t                  center_x;
    coord_t                  center_y;
    logic [COORD_BITS-2:0]   radius;
    logic [COORD_BITS-2:0]   scale_factor;
    coord_t                  t_min;
    coord_t                  t_max;
  } rci_in_t;

  typedef struct packed {
    logic   found;
    coord_t hit_t;
    coord_t hit_x;
    coord_t hit_y;
    norm_t  normal_x;
    norm_t  normal_y;
  } rci_out_t;

  typedef struct packed {
    coord_t ox0;
    coord_t oy0;
    coord_t dx;
    coord_t dy;
    coord_t cx;
    coord_t cy;
    coord_t tmin;
    coord_t tmax;
    coord_t a;
    coord_t h;
    logic   ok;
  } side_t;

  typedef struct packed {
    side_t       side;
    coord_t      disc;
    logic [35:0] rem;
    logic [31:0] root;
  } sq1_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] m0;
    logic [31:0] m1;
    logic        neg0;
    logic        neg1;
    logic        ov0;
    logic        ov1;
    logic [32:0] rem0;
    logic [32:0] rem1;
    logic [31:0] q0;
    logic [31:0] q1;
  } div1_t;

  typedef struct packed {
    coord_t ox0;
    coord_t oy0;
    coord_t dx;
    coord_t dy;
    coord_t cx;
    coord_t cy;
    coord_t t;
    coord_t px;
    coord_t py;
    coord_t nx;
    coord_t ny;
    logic   hit;
  } pt_t;

  typedef struct packed {
    pt_t         pt;
    logic [63:0] tgt;
    logic [35:0] rem;
    logic [31:0] root;
  } sq2_t;

  typedef struct packed {
    coord_t      t;
    coord_t      px;
    coord_t      py;
    logic        hit;
    logic        negx;
    logic        negy;
    logic        small_len;
    norm_t       fx;
    norm_t       fy;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] d;
    logic [32:0] remx;
    logic [32:0] remy;
    logic [15:0] qx;
    logic [15:0] qy;
  } div2_t;

endpackage
`default_nettype wire

FILE: rtl/ray_circle_intersection_unit.sv
// Top level: fully pipelined 2D ray/circle intersection in Q16.16.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | in_req_i  (rci_pkg::rci_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_req_o (rci_pkg::rci_out_t)
//
// One request enters per cycle unless the output holds; each result passes through all PIPE_DEPTH stages.
// The depth is set by the two square roots (one root bit per stage) and the two
// divisions (one quotient bit per stage), each as its own register chain.
// Reset clears only the valid chain; the data stages carry no reset.
// When the output register holds a result that is not taken, every stage holds,
// so nothing is dropped or duplicated; bubbles move through with valid low.
`default_nettype none
module ray_circle_intersection_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rci_pkg::rci_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rci_pkg::rci_out_t out_req_o
);
  import rci_pkg::*;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [33:0] sx34(input coord_t v);
    return {{2{v[31]}}, v};
  endfunction

  // clamp a 34-bit sum to the coordinate range
  function automatic coord_t sat34(input logic signed [33:0] v);
    if (!v[33] && (v[32] || v[31])) return 32'sh7FFF_FFFF;
    if (v[33] && !(v[32] && v[31])) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input coord_t v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // signed result from a magnitude, clamped
  function automatic coord_t sof(input logic [47:0] m, input logic neg);
    if (neg) begin
      if (m > 48'h0000_8000_0000) return 32'sh8000_0000;
      return ~m[31:0] + 32'd1;
    end
    if (m > 48'h0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    return m[31:0];
  endfunction

  // Q16.16 product, magnitude truncated, saturated
  function automatic coord_t mulq(input coord_t a, input coord_t b);
    logic [63:0] p;
    p = 64'(mag32(a)) * 64'(mag32(b));
    return sof(p[63:FRAC_BITS], a[31] ^ b[31]);
  endfunction

  // one step of the digit-by-digit square root: {root, rem}
  function automatic logic [67:0] sqstep(input logic [35:0] rem, input logic [31:0] root,
                                         input logic [1:0] pair);
    logic [35:0] rem2;
    logic [35:0] trial;
    rem2  = {rem[33:0], pair};
    trial = {2'b00, root, 2'b01};
    if (rem2 >= trial) return {root[30:0], 1'b1, rem2 - trial};
    return {root[30:0], 1'b0, rem2};
  endfunction

  // one restoring division step: {quotient bit, rem}
  function automatic logic [33:0] dstep(input logic [32:0] rem, input logic nb,
                                        input logic [32:0] d);
    logic [33:0] rem2;
    logic [33:0] dd;
    rem2 = {rem, nb};
    dd   = {1'b0, d};
    if (rem2 >= dd) return {1'b1, 33'(rem2 - dd)};
    return {1'b0, rem2[32:0]};
  endfunction

  function automatic norm_t to_q14(input coord_t v);
    logic [29:0] m;
    m = 30'(mag32(v) >> (FRAC_BITS - 14));
    if (v[31]) begin
      if (m > 30'd32768) return 16'sh8000;
      return 16'(~m + 30'd1);
    end
    if (m > 30'd32767) return 16'sh7FFF;
    return m[15:0];
  endfunction

  // ---------------------------------------------------------------- control
  logic                  pipe_adv;
  logic [PIPE_DEPTH-1:0] vld_q;

  // whole pipe moves unless the output holds a result that is not taken
  assign pipe_adv   = !vld_q[PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o = pipe_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // offsets O - C, effective radius, D.D terms
  side_t  s1_side_d, s1_side_q;
  coord_t s1_r_d, s1_r_q, s1_ox_d, s1_ox_q, s1_oy_d, s1_oy_q;
  coord_t s1_dxx_d, s1_dxx_q, s1_dyy_d, s1_dyy_q;

  always_comb begin
    s1_side_d      = '0;
    s1_side_d.ox0  = in_req_i.origin_x;
    s1_side_d.oy0  = in_req_i.origin_y;
    s1_side_d.dx   = in_req_i.dir_x;
    s1_side_d.dy   = in_req_i.dir_y;
    s1_side_d.cx   = in_req_i.center_x;
    s1_side_d.cy   = in_req_i.center_y;
    s1_side_d.tmin = in_req_i.t_min;
    s1_side_d.tmax = in_req_i.t_max;
    s1_r_d   = mulq({1'b0, in_req_i.radius}, {1'b0, in_req_i.scale_factor});
    s1_ox_d  = sat34(sx34(in_req_i.origin_x) - sx34(in_req_i.center_x));
    s1_oy_d  = sat34(sx34(in_req_i.origin_y) - sx34(in_req_i.center_y));
    s1_dxx_d = mulq(in_req_i.dir_x, in_req_i.dir_x);
    s1_dyy_d = mulq(in_req_i.dir_y, in_req_i.dir_y);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s1_side_q <= s1_side_d;
      s1_r_q    <= s1_r_d;
      s1_ox_q   <= s1_ox_d;
      s1_oy_q   <= s1_oy_d;
      s1_dxx_q  <= s1_dxx_d;
      s1_dyy_q  <= s1_dyy_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // a = D.D, products for h and c
  side_t  s2_side_d, s2_side_q;
  coord_t s2_hx_q, s2_hy_q, s2_cxx_q, s2_cyy_q, s2_rr_q;

  always_comb begin
    s2_side_d   = s1_side_q;
    s2_side_d.a = sat34(sx34(s1_dxx_q) + sx34(s1_dyy_q));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s2_side_q <= s2_side_d;
      s2_hx_q   <= mulq(s1_ox_q, s1_side_q.dx);
      s2_hy_q   <= mulq(s1_oy_q, s1_side_q.dy);
      s2_cxx_q  <= mulq(s1_ox_q, s1_ox_q);
      s2_cyy_q  <= mulq(s1_oy_q, s1_oy_q);
      s2_rr_q   <= mulq(s1_r_q, s1_r_q);
    end
  end

  // ---------------------------------------------------------------- stage 3
  // h = (O-C).D, c = |O-C|^2 - r^2
  side_t  s3_side_d, s3_side_q;
  coord_t s3_c_d, s3_c_q;

  always_comb begin
    s3_side_d   = s2_side_q;
    s3_side_d.h = sat34(sx34(s2_hx_q) + sx34(s2_hy_q));
    s3_c_d      = sat34(sx34(sat34(sx34(s2_cxx_q) + sx34(s2_cyy_q))) - sx34(s2_rr_q));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s3_side_q <= s3_side_d;
      s3_c_q    <= s3_c_d;
    end
  end

  // ---------------------------------------------------------------- stage 4
  side_t  s4_side_q;
  coord_t s4_hh_q, s4_ac_q;

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s4_side_q <= s3_side_q;
      s4_hh_q   <= mulq(s3_side_q.h, s3_side_q.h);
      s4_ac_q   <= mulq(s3_side_q.a, s3_c_q);
    end
  end

  // ---------------------------------------------------------------- sqrt of disc
  // disc = h^2 - a*c; a hit needs a > 0 and disc >= 0
  sq1_t sq1_d;
  sq1_t sq1_q [0:SQ1_STEPS];

  always_comb begin
    sq1_d         = '0;
    sq1_d.side    = s4_side_q;
    sq1_d.disc    = sat34(sx34(s4_hh_q) - sx34(s4_ac_q));
    sq1_d.side.ok = !s4_side_q.a[31] && (s4_side_q.a != '0) && !sq1_d.disc[31];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      sq1_q[0] <= sq1_d;
    end
  end

  for (genvar k = 0; k < SQ1_STEPS; k++) begin : g_sq1
    logic [47:0] tg;
    logic [67:0] st;
    sq1_t        stp_d;
    assign tg = {sq1_q[k].disc, 16'h0000};
    assign st = sqstep(sq1_q[k].rem, sq1_q[k].root, tg[47-2*k -: 2]);
    always_comb begin
      stp_d      = sq1_q[k];
      stp_d.root = st[67:36];
      stp_d.rem  = st[35:0];
    end
    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        sq1_q[k+1] <= stp_d;
      end
    end
  end

  // ---------------------------------------------------------------- root division
  // t = (-h -/+ s) / a, two lanes side by side
  div1_t             dv1_d;
  div1_t             dv1_q [0:DIV1_STEPS];
  logic signed [33:0] dv1_s;
  coord_t            dv1_n0, dv1_n1;

  always_comb begin
    dv1_s       = $signed({2'b00, sq1_q[SQ1_STEPS].root});
    dv1_n0      = sat34(-sx34(sq1_q[SQ1_STEPS].side.h) - dv1_s);
    dv1_n1      = sat34(-sx34(sq1_q[SQ1_STEPS].side.h) + dv1_s);
    dv1_d       = '0;
    dv1_d.side  = sq1_q[SQ1_STEPS].side;
    dv1_d.m0    = mag32(dv1_n0);
    dv1_d.m1    = mag32(dv1_n1);
    dv1_d.neg0  = dv1_n0[31];
    dv1_d.neg1  = dv1_n1[31];
    // quotient would not fit 32 bits: result saturates
    dv1_d.ov0   = {16'h0000, dv1_d.m0} >= {dv1_d.side.a, 16'h0000};
    dv1_d.ov1   = {16'h0000, dv1_d.m1} >= {dv1_d.side.a, 16'h0000};
    dv1_d.rem0  = 33'(dv1_d.m0[31:16]);
    dv1_d.rem1  = 33'(dv1_d.m1[31:16]);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      dv1_q[0] <= dv1_d;
    end
  end

  for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_div1
    logic        nb0, nb1;
    logic [33:0] st0, st1;
    div1_t       stp_d;
    if (i < 16) begin : g_bits
      assign nb0 = dv1_q[i].m0[15-i];
      assign nb1 = dv1_q[i].m1[15-i];
    end else begin : g_zero
      assign nb0 = 1'b0;
      assign nb1 = 1'b0;
    end
    assign st0 = dstep(dv1_q[i].rem0, nb0, {1'b0, dv1_q[i].side.a});
    assign st1 = dstep(dv1_q[i].rem1, nb1, {1'b0, dv1_q[i].side.a});
    always_comb begin
      stp_d      = dv1_q[i];
      stp_d.rem0 = st0[32:0];
      stp_d.rem1 = st1[32:0];
      stp_d.q0   = {dv1_q[i].q0[30:0], st0[33]};
      stp_d.q1   = {dv1_q[i].q1[30:0], st1[33]};
    end
    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        dv1_q[i+1] <= stp_d;
      end
    end
  end

  // ---------------------------------------------------------------- root select
  // nearer root if inside [t_min, t_max], else the farther one
  div1_t  sel_in;
  coord_t sel_t0, sel_t1;
  logic   sel_in0, sel_in1;
  pt_t    sel_d, sel_q;

  always_comb begin
    sel_in  = dv1_q[DIV1_STEPS];
    sel_t0  = sel_in.ov0 ? sof('1, sel_in.neg0) : sof({16'h0000, sel_in.q0}, sel_in.neg0);
    sel_t1  = sel_in.ov1 ? sof('1, sel_in.neg1) : sof({16'h0000, sel_in.q1}, sel_in.neg1);
    sel_in0 = (sel_t0 >= sel_in.side.tmin) && (sel_t0 <= sel_in.side.tmax);
    sel_in1 = (sel_t1 >= sel_in.side.tmin) && (sel_t1 <= sel_in.side.tmax);
    sel_d     = '0;
    sel_d.ox0 = sel_in.side.ox0;
    sel_d.oy0 = sel_in.side.oy0;
    sel_d.dx  = sel_in.side.dx;
    sel_d.dy  = sel_in.side.dy;
    sel_d.cx  = sel_in.side.cx;
    sel_d.cy  = sel_in.side.cy;
    sel_d.t   = sel_in0 ? sel_t0 : sel_t1;
    sel_d.hit = sel_in.side.ok && (sel_in0 || sel_in1);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      sel_q <= sel_d;
    end
  end

  // ---------------------------------------------------------------- hit point
  // p1: D*t, p2: P = O + D*t, p3: P - C, p4: squares of P - C
  pt_t         p1_d, p1_q, p2_d, p2_q, p3_d, p3_q;
  logic [63:0] p4_sqx_q, p4_sqy_q;
  pt_t         p4_q;

  always_comb begin
    p1_d    = sel_q;
    p1_d.px = mulq(sel_q.dx, sel_q.t);
    p1_d.py = mulq(sel_q.dy, sel_q.t);
    p2_d    = p1_q;
    p2_d.px = sat34(sx34(p1_q.ox0) + sx34(p1_q.px));
    p2_d.py = sat34(sx34(p1_q.oy0) + sx34(p1_q.py));
    p3_d    = p2_q;
    p3_d.nx = sat34(sx34(p2_q.px) - sx34(p2_q.cx));
    p3_d.ny = sat34(sx34(p2_q.py) - sx34(p2_q.cy));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      p1_q     <= p1_d;
      p2_q     <= p2_d;
      p3_q     <= p3_d;
      p4_q     <= p3_q;
      p4_sqx_q <= 64'(mag32(p3_q.nx)) * 64'(mag32(p3_q.nx));
      p4_sqy_q <= 64'(mag32(p3_q.ny)) * 64'(mag32(p3_q.ny));
    end
  end

  // ---------------------------------------------------------------- |P - C|
  sq2_t sq2_d;
  sq2_t sq2_q [0:SQ2_STEPS];

  always_comb begin
    sq2_d     = '0;
    sq2_d.pt  = p4_q;
    sq2_d.tgt = p4_sqx_q + p4_sqy_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      sq2_q[0] <= sq2_d;
    end
  end

  for (genvar k = 0; k < SQ2_STEPS; k++) begin : g_sq2
    logic [67:0] st;
    sq2_t        stp_d;
    assign st = sqstep(sq2_q[k].rem, sq2_q[k].root, sq2_q[k].tgt[63-2*k -: 2]);
    always_comb begin
      stp_d      = sq2_q[k];
      stp_d.root = st[67:36];
      stp_d.rem  = st[35:0];
    end
    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        sq2_q[k+1] <= stp_d;
      end
    end
  end

  // ---------------------------------------------------------------- normal
  // n = (P - C) * 2^14 / |P - C|; zero length keeps P - C as is in Q2.14
  div2_t dv2_d;
  div2_t dv2_q [0:DIV2_STEPS];
  pt_t   dv2_pt;

  always_comb begin
    dv2_pt          = sq2_q[SQ2_STEPS].pt;
    dv2_d           = '0;
    dv2_d.t         = dv2_pt.t;
    dv2_d.px        = dv2_pt.px;
    dv2_d.py        = dv2_pt.py;
    dv2_d.hit       = dv2_pt.hit;
    dv2_d.negx      = dv2_pt.nx[31];
    dv2_d.negy      = dv2_pt.ny[31];
    dv2_d.small_len = (sq2_q[SQ2_STEPS].root == '0);
    dv2_d.fx        = to_q14(dv2_pt.nx);
    dv2_d.fy        = to_q14(dv2_pt.ny);
    dv2_d.mx        = mag32(dv2_pt.nx);
    dv2_d.my        = mag32(dv2_pt.ny);
    dv2_d.d         = sq2_q[SQ2_STEPS].root;
    dv2_d.remx      = 33'(dv2_d.mx[31:2]);
    dv2_d.remy      = 33'(dv2_d.my[31:2]);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      dv2_q[0] <= dv2_d;
    end
  end

  for (genvar i = 0; i < DIV2_STEPS; i++) begin : g_div2
    logic        nbx, nby;
    logic [33:0] stx, sty;
    div2_t       stp_d;
    if (i < 2) begin : g_bits
      assign nbx = dv2_q[i].mx[1-i];
      assign nby = dv2_q[i].my[1-i];
    end else begin : g_zero
      assign nbx = 1'b0;
      assign nby = 1'b0;
    end
    assign stx = dstep(dv2_q[i].remx, nbx, {1'b0, dv2_q[i].d});
    assign sty = dstep(dv2_q[i].remy, nby, {1'b0, dv2_q[i].d});
    always_comb begin
      stp_d      = dv2_q[i];
      stp_d.remx = stx[32:0];
      stp_d.remy = sty[32:0];
      stp_d.qx   = {dv2_q[i].qx[14:0], stx[33]};
      stp_d.qy   = {dv2_q[i].qy[14:0], sty[33]};
    end
    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        dv2_q[i+1] <= stp_d;
      end
    end
  end

  // ---------------------------------------------------------------- output
  div2_t       fin;
  logic [15:0] fin_cx, fin_cy;
  rci_out_t    out_d, out_q;

  always_comb begin
    fin    = dv2_q[DIV2_STEPS];
    fin_cx = fin.qx[15] ? 16'h7FFF : fin.qx;
    fin_cy = fin.qy[15] ? 16'h7FFF : fin.qy;
    out_d  = '0;
    if (fin.hit) begin
      out_d.found = 1'b1;
      out_d.hit_t = fin.t;
      out_d.hit_x = fin.px;
      out_d.hit_y = fin.py;
      if (fin.small_len) begin
        out_d.normal_x = fin.fx;
        out_d.normal_y = fin.fy;
      end else begin
        out_d.normal_x = fin.negx ? (~fin_cx + 16'd1) : fin_cx;
        out_d.normal_y = fin.negy ? (~fin_cy + 16'd1) : fin_cy;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign out_req_o   = out_q;

endmodule
`default_nettype wire
